[rtl/cluster_axis_extent_top_macros.svh]
// ----------------------------------------------------------------------------
// Cluster axis extent: assertion macros
// Shared concurrent assertion forms for the cluster axis extent RTL.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_AXIS_EXTENT_TOP_MACROS_SVH
`define CLUSTER_AXIS_EXTENT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CAE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CAE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cae_pkg.sv]
// ----------------------------------------------------------------------------
// Cluster axis extent package
// Widths, register indexes, multiplier ops and controller/datapath types.
// ----------------------------------------------------------------------------
package cae_pkg;

    // Field and accumulator widths
    localparam int COORD_W   = 16;
    localparam int COUNT_W   = 17;
    localparam int SUM_W     = 32;
    localparam int SQ_W      = 47;
    localparam int SQ_LO_W   = 24;
    localparam int PROD_W    = 64;
    localparam int LEN_W     = 16;

    // Default point capacity per cluster
    localparam int MAX_POINTS_DEF = 65536;

    // Mean divider: the quotient always fits 16 bits, so 16 steps suffice
    localparam int DIV_STEPS = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_MAX = 1'b1;

    // Min/max tracker start values
    localparam logic signed [COORD_W-1:0] LOWEST_RST  = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] HIGHEST_RST = 16'sh8000;

    // Shared multiplier operations, issued in this order
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_NX_LO,
        MUL_NX_HI,
        MUL_SX,
        MUL_NY_LO,
        MUL_NY_HI,
        MUL_SY
    } t_mul_op;

    localparam int NUM_MUL_OPS = 6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    acc_en;
        logic    start;
        logic    div_step;
        t_mul_op mul_op;
        logic    spread_en;
        logic    axis_en;
        logic    out_load;
    } t_dp_cmd;

    // Result register contents
    typedef struct packed {
        logic               is_match;
        logic               along_y;
        logic [LEN_W-1:0]   extent;
        logic [COORD_W-1:0] mean_x;
        logic [COORD_W-1:0] mean_y;
        logic [COORD_W-1:0] mean_z;
        logic [COORD_W-1:0] start_along;
        logic [COORD_W-1:0] end_along;
        logic [COUNT_W-1:0] point_count;
    } t_result;

endpackage

[rtl/cae_in_if.sv]
// ----------------------------------------------------------------------------
// Cluster axis extent point channel
// Valid/ready channel carrying one cluster point per transaction.
// ----------------------------------------------------------------------------
interface cae_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [cae_pkg::COORD_W-1:0] pos_x;
    logic signed [cae_pkg::COORD_W-1:0] pos_y;
    logic signed [cae_pkg::COORD_W-1:0] pos_z;
    logic                              final_point;

    modport source (output valid, pos_x, pos_y, pos_z, final_point, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, final_point, output ready);
endinterface

[rtl/cae_out_if.sv]
// ----------------------------------------------------------------------------
// Cluster axis extent result channel
// Valid/ready channel carrying one cluster summary per transaction.
// ----------------------------------------------------------------------------
interface cae_out_if;
    logic                               valid;
    logic                               ready;
    logic                               is_match;
    logic                               along_y;
    logic        [cae_pkg::LEN_W-1:0]   extent;
    logic signed [cae_pkg::COORD_W-1:0] mean_x;
    logic signed [cae_pkg::COORD_W-1:0] mean_y;
    logic signed [cae_pkg::COORD_W-1:0] mean_z;
    logic signed [cae_pkg::COORD_W-1:0] start_along;
    logic signed [cae_pkg::COORD_W-1:0] end_along;
    logic        [cae_pkg::COUNT_W-1:0] point_count;

    modport source (output valid, is_match, along_y, extent, mean_x, mean_y,
                    mean_z, start_along, end_along, point_count, input ready);
    modport sink   (input valid, is_match, along_y, extent, mean_x, mean_y,
                    mean_z, start_along, end_along, point_count, output ready);
endinterface

[rtl/cae_datapath.sv]
// ----------------------------------------------------------------------------
// Cluster axis extent datapath
// Accumulators, shared spread multiplier, mean dividers and result register.
// ----------------------------------------------------------------------------
module cae_datapath #(
    parameter int MAX_POINTS = cae_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cae_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [cae_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [cae_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [cae_pkg::COORD_W-1:0]   i_pos_z,
    input  logic                                 i_cfg_we,
    input  logic        [cae_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [cae_pkg::LEN_W-1:0]     i_cfg_data,
    output cae_pkg::t_result                     o_result
);

    localparam int LANES = 3;
    localparam int CW    = cae_pkg::COORD_W;
    localparam int NW    = cae_pkg::COUNT_W;
    localparam int SW    = cae_pkg::SUM_W;
    localparam int QW    = cae_pkg::SQ_W;
    localparam int LW    = cae_pkg::SQ_LO_W;
    localparam int PW    = cae_pkg::PROD_W;
    localparam int HW    = QW - LW;

    // Configuration registers
    logic [cae_pkg::LEN_W-1:0] r_len_min;
    logic [cae_pkg::LEN_W-1:0] r_len_max;

    // Cluster accumulators (lane 0 = x, 1 = y, 2 = z)
    logic        [NW-1:0] r_count;
    logic signed [SW-1:0] r_sum [LANES];
    logic        [QW-1:0] r_sumsq_x;
    logic        [QW-1:0] r_sumsq_y;
    logic signed [CW-1:0] r_lo_x;
    logic signed [CW-1:0] r_hi_x;
    logic signed [CW-1:0] r_lo_y;
    logic signed [CW-1:0] r_hi_y;

    logic signed [2*CW-1:0] w_sq_x;
    logic signed [2*CW-1:0] w_sq_y;
    logic                   w_room;

    // Spread evaluation
    logic [SW-1:0]    w_mag [LANES];
    logic [SW-1:0]    w_mul_a;
    logic [SW-1:0]    w_mul_b;
    logic [PW-1:0]    w_prod;
    logic [PW-1:0]    r_prod;
    cae_pkg::t_mul_op r_prod_op;
    logic [PW-1:0]    r_nsq_x;
    logic [PW-1:0]    r_nsq_y;
    logic [PW-1:0]    r_sq_x;
    logic [PW-1:0]    r_sq_y;
    logic [PW-1:0]    r_spread_x;
    logic [PW-1:0]    r_spread_y;
    logic             r_along_y;

    // Mean dividers
    logic [NW-1:0] r_rem [LANES];
    logic [CW-1:0] r_quo [LANES];
    logic          r_neg [LANES];
    logic [NW:0]   w_trial [LANES];
    logic          w_fits [LANES];
    logic [CW-1:0] w_center [LANES];

    // Result selection
    logic [CW-1:0]             w_lo;
    logic [CW-1:0]             w_hi;
    logic [cae_pkg::LEN_W-1:0] w_extent;
    cae_pkg::t_result          r_result;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_min <= '0;
            r_len_max <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cae_pkg::CFG_LENGTH_MIN: r_len_min <= i_cfg_data;
                cae_pkg::CFG_LENGTH_MAX: r_len_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-point accumulation, cleared when the result is captured
    assign w_sq_x = i_pos_x * i_pos_x;
    assign w_sq_y = i_pos_y * i_pos_y;
    assign w_room = r_count < NW'(MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_count   <= '0;
            for (int l = 0; l < LANES; l++) r_sum[l] <= '0;
            r_sumsq_x <= '0;
            r_sumsq_y <= '0;
            r_lo_x    <= cae_pkg::LOWEST_RST;
            r_hi_x    <= cae_pkg::HIGHEST_RST;
            r_lo_y    <= cae_pkg::LOWEST_RST;
            r_hi_y    <= cae_pkg::HIGHEST_RST;
        end else if (i_cmd.acc_en && w_room) begin
            r_count   <= r_count + NW'(1);
            r_sum[0]  <= r_sum[0] + SW'(i_pos_x);
            r_sum[1]  <= r_sum[1] + SW'(i_pos_y);
            r_sum[2]  <= r_sum[2] + SW'(i_pos_z);
            r_sumsq_x <= r_sumsq_x + {{(QW-2*CW){1'b0}}, w_sq_x};
            r_sumsq_y <= r_sumsq_y + {{(QW-2*CW){1'b0}}, w_sq_y};
            if (i_pos_x < r_lo_x) r_lo_x <= i_pos_x;
            if (i_pos_x > r_hi_x) r_hi_x <= i_pos_x;
            if (i_pos_y < r_lo_y) r_lo_y <= i_pos_y;
            if (i_pos_y > r_hi_y) r_hi_y <= i_pos_y;
        end
    end

    // Sum magnitudes; -2^31 maps to 2^31, which still fits unsigned
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_mag[l] = r_sum[l][SW-1] ? SW'(-r_sum[l]) : SW'(r_sum[l]);
        end
    end

    // Shared multiplier operand select; n*sumsq is split into two halves
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (i_cmd.mul_op)
            cae_pkg::MUL_NX_LO: begin
                w_mul_a = SW'(r_count);
                w_mul_b = SW'(r_sumsq_x[LW-1:0]);
            end
            cae_pkg::MUL_NX_HI: begin
                w_mul_a = SW'(r_count);
                w_mul_b = SW'(r_sumsq_x[QW-1:LW]);
            end
            cae_pkg::MUL_SX: begin
                w_mul_a = w_mag[0];
                w_mul_b = w_mag[0];
            end
            cae_pkg::MUL_NY_LO: begin
                w_mul_a = SW'(r_count);
                w_mul_b = SW'(r_sumsq_y[LW-1:0]);
            end
            cae_pkg::MUL_NY_HI: begin
                w_mul_a = SW'(r_count);
                w_mul_b = SW'(r_sumsq_y[QW-1:LW]);
            end
            cae_pkg::MUL_SY: begin
                w_mul_a = w_mag[1];
                w_mul_b = w_mag[1];
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Product register, then accumulation into the spread terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_op <= cae_pkg::MUL_NONE;
        end else begin
            r_prod_op <= i_cmd.mul_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_prod_op)
            cae_pkg::MUL_NX_LO: r_nsq_x <= r_prod;
            cae_pkg::MUL_NX_HI: r_nsq_x <= r_nsq_x + {r_prod[NW+HW-1:0], {LW{1'b0}}};
            cae_pkg::MUL_SX:    r_sq_x  <= r_prod;
            cae_pkg::MUL_NY_LO: r_nsq_y <= r_prod;
            cae_pkg::MUL_NY_HI: r_nsq_y <= r_nsq_y + {r_prod[NW+HW-1:0], {LW{1'b0}}};
            cae_pkg::MUL_SY:    r_sq_y  <= r_prod;
            default: ;
        endcase
        if (i_cmd.spread_en) begin
            r_spread_x <= (r_nsq_x >= r_sq_x) ? r_nsq_x - r_sq_x : '0;
            r_spread_y <= (r_nsq_y >= r_sq_y) ? r_nsq_y - r_sq_y : '0;
        end
        // Ties go to the Y axis
        if (i_cmd.axis_en) r_along_y <= !(r_spread_x > r_spread_y);
    end

    // Restoring dividers, one quotient bit per lane per step.
    // |sum| <= 32768*n, so the top half of |sum| is already below n.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_trial[l] = {r_rem[l], r_quo[l][CW-1]};
            w_fits[l]  = w_trial[l] >= {1'b0, r_count};
            w_center[l] = (r_count == '0) ? '0 :
                          (r_neg[l] ? CW'(-r_quo[l]) : r_quo[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_cmd.start) begin
                r_rem[l] <= NW'(w_mag[l][SW-1:CW]);
                r_quo[l] <= w_mag[l][CW-1:0];
                r_neg[l] <= r_sum[l][SW-1];
            end else if (i_cmd.div_step) begin
                r_rem[l] <= w_fits[l] ? NW'(w_trial[l] - {1'b0, r_count}) : w_trial[l][NW-1:0];
                r_quo[l] <= {r_quo[l][CW-2:0], w_fits[l]};
            end
        end
    end

    // Extent along the dominant axis and the result register
    assign w_lo     = r_along_y ? r_lo_y : r_lo_x;
    assign w_hi     = r_along_y ? r_hi_y : r_hi_x;
    assign w_extent = w_hi - w_lo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result.is_match    <= (w_extent >= r_len_min) && (w_extent <= r_len_max);
            r_result.along_y     <= r_along_y;
            r_result.extent      <= w_extent;
            r_result.mean_x      <= w_center[0];
            r_result.mean_y      <= w_center[1];
            r_result.mean_z      <= w_center[2];
            r_result.start_along <= w_lo;
            r_result.end_along   <= w_hi;
            r_result.point_count <= r_count;
        end
    end

    assign o_result = r_result;

endmodule

[rtl/cae_ctrl.sv]
// ----------------------------------------------------------------------------
// Cluster axis extent controller
// Sequences accumulation, spread/mean evaluation and the result handoff.
// ----------------------------------------------------------------------------
`include "cluster_axis_extent_top_macros.svh"

module cae_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_final_point,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output cae_pkg::t_dp_cmd o_cmd
);

    localparam int STEP_W = $clog2(cae_pkg::DIV_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_MUL_END = STEP_W'(cae_pkg::NUM_MUL_OPS);
    localparam logic [STEP_W-1:0] STEP_SPREAD  = STEP_W'(cae_pkg::NUM_MUL_OPS + 1);
    localparam logic [STEP_W-1:0] STEP_AXIS    = STEP_W'(cae_pkg::NUM_MUL_OPS + 2);
    localparam logic [STEP_W-1:0] STEP_LAST    = STEP_W'(cae_pkg::DIV_STEPS);

    typedef enum logic [1:0] {
        S_ACCUM,
        S_CALC,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              w_acc;
    logic              w_calc;

    assign o_in_ready  = (r_state == S_ACCUM);
    assign o_out_valid = r_out_valid;
    assign w_acc       = o_in_ready && i_in_valid;
    assign w_calc      = (r_state == S_CALC);

    // Command decode from state and step
    always_comb begin
        o_cmd.acc_en    = w_acc;
        o_cmd.start     = w_calc && (r_step == '0);
        o_cmd.div_step  = w_calc && (r_step != '0);
        o_cmd.mul_op    = (w_calc && r_step < STEP_MUL_END) ?
                          cae_pkg::t_mul_op'(3'(r_step) + 3'd1) : cae_pkg::MUL_NONE;
        o_cmd.spread_en = w_calc && (r_step == STEP_SPREAD);
        o_cmd.axis_en   = w_calc && (r_step == STEP_AXIS);
        o_cmd.out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    // State, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCUM;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_ACCUM: begin
                    if (w_acc && i_final_point) begin
                        r_state <= S_CALC;
                        r_step  <= '0;
                    end
                end
                S_CALC: begin
                    if (r_step == STEP_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_DONE: begin
                    if (o_cmd.out_load) r_state <= S_ACCUM;
                end
                default: r_state <= S_ACCUM;
            endcase
        end
    end

    // Checks
    `CAE_ASSERT_NXT(a_final_starts, i_clk, i_rst_n, w_acc && i_final_point, o_cmd.start, "final point did not start evaluation")
    `CAE_ASSERT_NXT(a_final_blocks, i_clk, i_rst_n, w_acc && i_final_point, !o_in_ready, "points accepted after final point")
    `CAE_ASSERT_IMP(a_div_no_points, i_clk, i_rst_n, o_cmd.div_step, !o_cmd.acc_en, "accumulation during division")
    `CAE_ASSERT_NXT(a_load_valid, i_clk, i_rst_n, o_cmd.out_load, o_out_valid, "captured result not presented")

endmodule

[rtl/cluster_axis_extent_top.sv]
// ----------------------------------------------------------------------------
// Cluster axis extent top level
// Per-cluster centroid, dominant horizontal axis and extent along it.
// ----------------------------------------------------------------------------
// Usage:
//   i_pt carries one point per transaction (pos_x/y/z in mm, final_point on
//   the last point of a cluster). Points are taken one per cycle while the
//   cluster accumulates; points past MAX_POINTS are dropped, but a dropped
//   final point still closes the cluster.
//   After the final point, ready drops while the shared spread multiplier
//   runs alongside a 16-step restoring divider per mean (one quotient bit
//   per cycle). The result then appears on o_res and the block accepts
//   points again.
//   The result sits in an output register; if the receiver stalls, the next
//   cluster can still be accumulated and evaluated, and only its capture
//   waits, with ready low, until the register frees up.
//   i_cfg_we/i_cfg_idx/i_cfg_data write length_min (0) and length_max (1);
//   write them only while no cluster is in flight.
//   Reset (synchronous, active low) clears the accumulators, sets the range
//   to [0, 65535] and empties the output register.
// ----------------------------------------------------------------------------
module cluster_axis_extent_top #(
    parameter int MAX_POINTS = cae_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    cae_in_if.sink                               i_pt,
    cae_out_if.source                            o_res,
    input  logic                                 i_cfg_we,
    input  logic        [cae_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [cae_pkg::LEN_W-1:0]     i_cfg_data
);

    cae_pkg::t_dp_cmd w_cmd;
    cae_pkg::t_result w_result;
    logic             w_in_ready;
    logic             w_out_valid;

    // Controller
    cae_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_pt.valid),
        .i_final_point (i_pt.final_point),
        .o_in_ready    (w_in_ready),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (w_out_valid),
        .o_cmd         (w_cmd)
    );

    // Datapath
    cae_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_pos_x    (i_pt.pos_x),
        .i_pos_y    (i_pt.pos_y),
        .i_pos_z    (i_pt.pos_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (w_result)
    );

    // Channel outputs
    assign i_pt.ready        = w_in_ready;
    assign o_res.valid       = w_out_valid;
    assign o_res.is_match    = w_result.is_match;
    assign o_res.along_y     = w_result.along_y;
    assign o_res.extent      = w_result.extent;
    assign o_res.mean_x      = w_result.mean_x;
    assign o_res.mean_y      = w_result.mean_y;
    assign o_res.mean_z      = w_result.mean_z;
    assign o_res.start_along = w_result.start_along;
    assign o_res.end_along   = w_result.end_along;
    assign o_res.point_count = w_result.point_count;

endmodule

[tb/cae_extent_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cluster axis extent checker
// Watches the point channel, the result channel and the register port of the
// cluster axis extent block. It keeps its own copy of the cluster
// accumulators and of the length range, and it predicts one summary for each
// point transaction that carries the last mark. Each result transaction is
// compared field by field with the oldest predicted summary.
// ----------------------------------------------------------------------------
module cae_extent_checker
    import cae_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cae_in_if                    i_pt,
    cae_out_if                   i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);

    // Shadow of the length range registers
    logic [LEN_W-1:0] range_lo;
    logic [LEN_W-1:0] range_hi;

    // Shadow of the cluster accumulators
    int                 n_points;
    longint             acc_x, acc_y, acc_z;
    longint unsigned    acc_xx, acc_yy;
    int                 min_x, max_x, min_y, max_y;

    // Predicted summaries, oldest first
    t_result            summary_q[$];
    int                 mismatches = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = summary_q.size();

    function automatic void clear_cluster();
        n_points = 0;
        acc_x    = 0;
        acc_y    = 0;
        acc_z    = 0;
        acc_xx   = 0;
        acc_yy   = 0;
        min_x    = int'(LOWEST_RST);
        max_x    = int'(HIGHEST_RST);
        min_y    = int'(LOWEST_RST);
        max_y    = int'(HIGHEST_RST);
    endfunction

    // n * sum(v^2) - sum(v)^2, i.e. n^2 times the variance
    function automatic longint unsigned spread(input longint unsigned n,
                                               input longint unsigned sq,
                                               input longint s);
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        m = (s < 0) ? longint'(-s) : longint'(s);
        a = n * sq;
        b = m * m;
        return (a >= b) ? a - b : 64'd0;
    endfunction

    // Signed division truncates toward zero
    function automatic longint average(input longint s, input int n);
        if (n == 0)
            return 0;
        return s / longint'(n);
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t cae_extent_checker: %s got %0d expected %0d",
                 $time, what, got, want);
        mismatches++;
    endtask

    // Register shadow, result comparison and accumulation, all on the edge
    always @(posedge i_clk) begin : monitor
        t_result         want;
        int              px, py, pz, lo, hi;
        logic            y_dom;
        if (!i_rst_n) begin
            range_lo = '0;
            range_hi = '1;
            clear_cluster();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LENGTH_MIN: range_lo = i_cfg_data;
                    CFG_LENGTH_MAX: range_hi = i_cfg_data;
                    default: ;
                endcase
            end

            // Result transaction against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                if (summary_q.size() == 0) begin
                    report_mismatch("result with no cluster closed, count",
                                    i_res.point_count, 0);
                end else begin
                    want = summary_q.pop_front();
                    if (i_res.is_match !== want.is_match)
                        report_mismatch("is_match", i_res.is_match, want.is_match);
                    if (i_res.along_y !== want.along_y)
                        report_mismatch("along_y", i_res.along_y, want.along_y);
                    if (i_res.extent !== want.extent)
                        report_mismatch("extent", i_res.extent, want.extent);
                    if (i_res.mean_x !== want.mean_x)
                        report_mismatch("mean_x", i_res.mean_x,
                                        $signed(want.mean_x));
                    if (i_res.mean_y !== want.mean_y)
                        report_mismatch("mean_y", i_res.mean_y,
                                        $signed(want.mean_y));
                    if (i_res.mean_z !== want.mean_z)
                        report_mismatch("mean_z", i_res.mean_z,
                                        $signed(want.mean_z));
                    if (i_res.start_along !== want.start_along)
                        report_mismatch("start_along", i_res.start_along,
                                        $signed(want.start_along));
                    if (i_res.end_along !== want.end_along)
                        report_mismatch("end_along", i_res.end_along,
                                        $signed(want.end_along));
                    if (i_res.point_count !== want.point_count)
                        report_mismatch("point_count", i_res.point_count,
                                        want.point_count);
                end
            end

            // Point transaction: accumulate unless the cluster is full
            if (i_pt.valid && i_pt.ready) begin
                px = i_pt.pos_x;
                py = i_pt.pos_y;
                pz = i_pt.pos_z;
                if (n_points < MAX_POINTS) begin
                    n_points++;
                    acc_x  += px;
                    acc_y  += py;
                    acc_z  += pz;
                    acc_xx += longint'(px * px);
                    acc_yy += longint'(py * py);
                    if (px < min_x) min_x = px;
                    if (px > max_x) max_x = px;
                    if (py < min_y) min_y = py;
                    if (py > max_y) max_y = py;
                end

                // Last point: summarize, ties go to Y
                if (i_pt.final_point) begin
                    y_dom = !(spread(n_points, acc_xx, acc_x) >
                              spread(n_points, acc_yy, acc_y));
                    lo = y_dom ? min_y : min_x;
                    hi = y_dom ? max_y : max_x;
                    want.along_y     = y_dom;
                    want.extent      = LEN_W'(hi - lo);
                    want.is_match    = (want.extent >= range_lo) &&
                                       (want.extent <= range_hi);
                    want.mean_x      = COORD_W'(average(acc_x, n_points));
                    want.mean_y      = COORD_W'(average(acc_y, n_points));
                    want.mean_z      = COORD_W'(average(acc_z, n_points));
                    want.start_along = COORD_W'(lo);
                    want.end_along   = COORD_W'(hi);
                    want.point_count = COUNT_W'(n_points);
                    summary_q.insert(summary_q.size(), want);
                    clear_cluster();
                end
            end
        end
    end

endmodule

[tb/tb_cluster_axis_extent_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cluster axis extent testbench
// Drives clusters of points into the block and lets the checker compare each
// cluster summary. A short directed part covers the coordinate extremes, both
// dominant axes, the tie and the range edges; random phases follow with new
// length ranges, varied cluster shapes and sender/receiver idling, and one
// long receiver hold-off while clusters keep coming.
// ----------------------------------------------------------------------------
module tb_cluster_axis_extent_top;
    import cae_pkg::*;

    localparam int     HALF_PERIOD  = 10;
    localparam int     SETTLE_CYC   = 24;      // idle time after every summary has drained
    localparam int     HOLD_CYCLES  = 400;
    localparam int     NUM_PHASES   = 8;
    localparam int     PHASE_ITEMS  = 200;
    localparam longint TIMEOUT_NS   = 64'd60_000_000;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum {SHAPE_SCATTER, SHAPE_ALONG_X, SHAPE_ALONG_Y, SHAPE_BLOB} t_shape;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [LEN_W-1:0]     cfg_data;

    int   gap_pct   = 0;
    int   stall_pct = 0;
    int   hold_left = 0;
    logic hold_req  = 1'b0;
    int   mismatches;
    int   pending;

    cae_in_if  pt_if ();
    cae_out_if res_if ();

    cluster_axis_extent_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cae_extent_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (pt_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("tb_cluster_axis_extent_top: FAIL");
        $finish;
    end

    // Result receiver: random stalls, or one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin gap_pct = 46; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 46; end
            IDLE_BOTH:     begin gap_pct = 20; stall_pct = 20; end
        endcase
    endtask

    // One point transaction; valid stays high on return
    task automatic send_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z,
                              input logic last);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            pt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid       <= 1'b1;
        pt_if.pos_x       <= x;
        pt_if.pos_y       <= y;
        pt_if.pos_z       <= z;
        pt_if.final_point <= last;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and let every summary drain
    task automatic wait_quiet();
        pt_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [LEN_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_range(input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi);
        write_reg(CFG_LENGTH_MIN, lo);
        write_reg(CFG_LENGTH_MAX, hi);
    endtask

    // One cluster of the given shape; lines get a small sideways jitter
    task automatic send_cluster(input int size, input t_shape shape);
        int len, x0, y0, x, y;
        len = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(4000);
        x0  = int'($urandom_range(65535 - len)) - 32768;
        y0  = int'($urandom_range(65535 - len)) - 32768;
        for (int k = 0; k < size; k++) begin
            case (shape)
                SHAPE_ALONG_X: begin
                    x = x0 + $urandom_range(len);
                    y = y0 + $urandom_range(len / 16);
                end
                SHAPE_ALONG_Y: begin
                    x = x0 + $urandom_range(len / 16);
                    y = y0 + $urandom_range(len);
                end
                SHAPE_BLOB: begin
                    x = x0 + $urandom_range(len / 64);
                    y = y0 + $urandom_range(len / 64);
                end
                default: begin
                    x = $urandom;
                    y = $urandom;
                end
            endcase
            send_point(COORD_W'(x), COORD_W'(y), COORD_W'($urandom), k == size - 1);
        end
    endtask

    initial begin : stimulus
        int phase_items;
        int size;
        int lo;
        pt_if.valid       = 1'b0;
        pt_if.pos_x       = '0;
        pt_if.pos_y       = '0;
        pt_if.pos_z       = '0;
        pt_if.final_point = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_LENGTH_MIN;
        cfg_data          = '0;
        i_rst_n           = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, both axes, tie, truncation of negative means
        send_point(16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1);
        send_point(16'sh8000, 16'sd0, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sd0, 16'sh8000, 1'b1);
        send_point(16'sd0, 16'sh8000, 16'sd5, 1'b0);
        send_point(16'sd0, 16'sh7FFF, -16'sd5, 1'b0);
        send_point(16'sd1, 16'sd0, 16'sd0, 1'b1);
        send_point(16'sd1, 16'sd1, 16'sd1, 1'b0);
        send_point(-16'sd1, -16'sd1, -16'sd1, 1'b1);
        send_point(-16'sd3, 16'sd7, -16'sd5, 1'b0);
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);

        // Directed: range edges, extent just inside and just outside
        wait_quiet();
        set_range(16'd100, 16'd200);
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd100, 16'sd3, 16'sd0, 1'b1);
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd200, 16'sd0, 16'sd0, 1'b1);
        send_point(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd201, 16'sd0, 16'sd0, 1'b1);
        send_point(16'sd10, 16'sd0, 16'sd0, 1'b0);
        send_point(16'sd10, 16'sd99, 16'sd0, 1'b1);

        // Random phases, each with its own length range and idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_quiet();
            case (ph)
                0: set_range(16'd0, 16'hFFFF);
                1: begin
                    lo = $urandom_range(300, 2000);
                    set_range(LEN_W'(lo), LEN_W'(lo + $urandom_range(3000)));
                end
                2: set_range(16'd3000, 16'd1000);          // inverted range
                3: set_range(16'd0, 16'd0);
                4: set_range(16'hFFFF, 16'hFFFF);
                5: set_range(LEN_W'($urandom), LEN_W'($urandom));
                6: set_range(16'd0, LEN_W'($urandom_range(65535)));
                default: set_range(LEN_W'($urandom_range(65535)), 16'hFFFF);
            endcase
            set_idling(t_idle_mode'(ph % 4));
            // Long receiver hold-off while clusters keep coming
            if (ph == 4)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                size = ($urandom_range(9) == 0) ? $urandom_range(12, 40)
                                                : $urandom_range(1, 8);
                send_cluster(size, t_shape'($urandom_range(3)));
                phase_items += size;
            end
        end

        wait_quiet();
        if (mismatches == 0 && pending == 0) begin
            $display("tb_cluster_axis_extent_top: PASS");
        end else begin
            $display("tb_cluster_axis_extent_top: FAIL");
        end
        $finish;
    end

endmodule
